### rtl/kcpe_pkg.sv
// ----------------------------------------------------------------------------
// kcpe_pkg
// Shared types and constants of the keyed command packet encoder.
// ----------------------------------------------------------------------------
package kcpe_pkg;

  localparam int unsigned MessageBytesDef = 16;

  localparam logic [3:0] ResetSessionCmd = 4'd13;
  localparam int unsigned PosOffset      = 2;
  localparam int unsigned PosReserve     = 6;

  // Configuration register indexes (byte address = 4 * index).
  localparam logic [2:0] RegPrime   = 3'd0;
  localparam logic [2:0] RegGen     = 3'd1;
  localparam logic [2:0] RegPartner = 3'd2;
  localparam logic [2:0] RegIdent   = 3'd3;
  localparam logic [2:0] RegMask    = 3'd4;

  localparam logic [7:0] PrimeRst = 8'd251;
  localparam logic [7:0] GenRst   = 8'd2;

  // Request to the shared remainder unit.
  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [7:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] remainder;
  } mod_rsp_t;

endpackage

### rtl/kcpe_mod_unit.sv
// ----------------------------------------------------------------------------
// kcpe_mod_unit
// Restoring remainder unit: 16-bit dividend modulo an 8-bit divisor, one
// bit per cycle. A zero divisor leaves the low byte of the dividend.
// ----------------------------------------------------------------------------
module kcpe_mod_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kcpe_pkg::mod_req_t req_i,
  output kcpe_pkg::mod_rsp_t rsp_o
);

  logic        busy_q;
  logic        done_q;
  logic [3:0]  cnt_q;
  logic [15:0] num_q;
  logic [7:0]  rem_q;
  logic [7:0]  div_q;
  logic [8:0]  trial;

  assign trial = {rem_q, num_q[15]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // With a zero divisor every trial subtracts nothing, so the low byte
  // of the dividend is what remains.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      div_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[14:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_q <= 8'(trial - {1'b0, div_q});
      end else begin
        rem_q <= trial[7:0];
      end
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

### rtl/keyed_command_packet_encoder_unit.sv
// ----------------------------------------------------------------------------
// keyed_command_packet_encoder_unit
// Builds a keyed, scrambled command message per request and streams it out
// one byte per transaction, with a session-reset message after a wrap.
// ----------------------------------------------------------------------------
// Operation: each message needs three 8-bit modular powers and two reductions,
// all on one remainder unit; the wait before the first byte is set by the
// exponent bits. Each byte is formed in StByte and held in StSend until the
// sink is ready.
// Throughput: one request at a time; in_ready_o is high only when idle.
// Reset: asynchronous, clears the sequencer, session counter and registers
// to their defaults (prime 251, generator 2, others zero).
module keyed_command_packet_encoder_unit #(
  parameter int unsigned MESSAGE_BYTES = kcpe_pkg::MessageBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  command_i,
  input  logic [7:0]  entropy_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  message_byte_o,
  output logic [4:0]  byte_index_o,
  output logic        end_of_message_o,
  output logic        end_of_run_o
);

  localparam int unsigned IdxW = $clog2(MESSAGE_BYTES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MESSAGE_BYTES - 1);
  localparam logic [7:0] PosDiv = 8'(MESSAGE_BYTES - kcpe_pkg::PosReserve);
  localparam logic [7:0] PosOff = 8'(kcpe_pkg::PosOffset);
  localparam logic [15:0] NBytes = 16'(MESSAGE_BYTES);

  typedef enum logic [3:0] {
    StIdle, StAMod, StPmBase, StPmLoop, StPmMulR, StPmSqr, StPosMod, StByte, StSend
  } state_e;

  typedef enum logic [1:0] {SelPub, SelPeer, SelSec} pm_sel_e;

  state_e  state_q;
  pm_sel_e sel_q;
  logic    issued_q;
  logic    second_q;

  logic [7:0] prime_q, gen_q, partner_q, ident_q, mask_q;
  logic [15:0] session_q;
  logic [3:0]  cmd_q;
  logic [7:0]  ent_q;
  logic [7:0]  sum_q;
  logic [7:0]  a_q, pub_q, peer_q, sec_q, pos_q;
  logic [7:0]  pm_c_q, pm_r_q, pm_d_q;
  logic [IdxW-1:0] idx_q;

  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic [4:0]  out_idx_q;
  logic        out_eom_q;
  logic        out_eor_q;

  kcpe_pkg::mod_req_t mod_req;
  kcpe_pkg::mod_rsp_t mod_rsp;

  logic [7:0]  mask_ent;
  logic [7:0]  sum_init;
  logic [7:0]  pm_base;
  logic [7:0]  pm_expo;
  logic [7:0]  idx8;
  logic [7:0]  plain_byte;
  logic [7:0]  rem;
  logic        cfg_wr;

  kcpe_mod_unit u_mod (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mod_req),
    .rsp_o (mod_rsp)
  );

  assign rem      = mod_rsp.remainder;
  assign mask_ent = mask_q + ent_q;
  // Sum over an all-zero buffer: every entry contributes mask plus entropy.
  assign sum_init = 8'(16'(mask_ent) * NBytes);
  assign idx8     = 8'(idx_q);
  assign cfg_wr   = psel && penable && pwrite;

  always_comb begin
    pm_base = gen_q;
    pm_expo = a_q;
    case (sel_q)
      SelPub:  begin pm_base = gen_q;  pm_expo = a_q;       end
      SelPeer: begin pm_base = gen_q;  pm_expo = partner_q; end
      SelSec:  begin pm_base = peer_q; pm_expo = a_q;       end
      default: begin pm_base = gen_q;  pm_expo = a_q;       end
    endcase
  end

  always_comb begin
    if (idx8 == pos_q) begin
      plain_byte = ident_q;
    end else if (idx8 == pos_q + 8'd1) begin
      plain_byte = {4'd0, cmd_q};
    end else if (idx8 == pos_q + 8'd2) begin
      plain_byte = session_q[7:0];
    end else if (idx8 == pos_q + 8'd3) begin
      plain_byte = session_q[15:8];
    end else begin
      plain_byte = sum_q;
    end
  end

  always_comb begin
    mod_req.start    = 1'b0;
    mod_req.dividend = {8'd0, sum_q};
    mod_req.divisor  = prime_q;
    case (state_q)
      StAMod: begin
        // The running sum is loaded in this cycle, so reduce its start value.
        mod_req.dividend = {8'd0, sum_init};
        mod_req.divisor  = prime_q - 8'd1;
      end
      StPmBase: begin
        mod_req.dividend = {8'd0, pm_base};
      end
      StPmMulR: begin
        mod_req.dividend = 16'(pm_r_q) * 16'(pm_c_q);
      end
      StPmSqr: begin
        mod_req.dividend = 16'(pm_c_q) * 16'(pm_c_q);
      end
      StPosMod: begin
        mod_req.divisor = PosDiv;
      end
      default: begin
      end
    endcase
    if (!issued_q && (state_q inside {StAMod, StPmBase, StPmMulR, StPmSqr, StPosMod})) begin
      mod_req.start = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      sel_q       <= SelPub;
      issued_q    <= 1'b0;
      second_q    <= 1'b0;
      prime_q     <= kcpe_pkg::PrimeRst;
      gen_q       <= kcpe_pkg::GenRst;
      partner_q   <= '0;
      ident_q     <= '0;
      mask_q      <= '0;
      session_q   <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (cfg_wr) begin
        case (paddr[4:2])
          kcpe_pkg::RegPrime:   prime_q   <= pwdata[7:0];
          kcpe_pkg::RegGen:     gen_q     <= pwdata[7:0];
          kcpe_pkg::RegPartner: partner_q <= pwdata[7:0];
          kcpe_pkg::RegIdent:   ident_q   <= pwdata[7:0];
          kcpe_pkg::RegMask:    mask_q    <= pwdata[7:0];
          default: begin
          end
        endcase
      end
      if (mod_req.start) begin
        issued_q <= 1'b1;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            cmd_q    <= command_i;
            ent_q    <= entropy_i;
            second_q <= 1'b0;
            state_q  <= StAMod;
          end
        end
        StAMod: begin
          if (!issued_q) begin
            sum_q <= sum_init;
          end else if (mod_rsp.done) begin
            issued_q <= 1'b0;
            a_q      <= rem;
            sel_q    <= SelPub;
            state_q  <= StPmBase;
          end
        end
        StPmBase: begin
          if (issued_q && mod_rsp.done) begin
            issued_q <= 1'b0;
            pm_c_q   <= rem;
            pm_r_q   <= 8'd1;
            pm_d_q   <= pm_expo;
            state_q  <= StPmLoop;
          end
        end
        StPmLoop: begin
          if (pm_d_q == 8'd0) begin
            case (sel_q)
              SelPub: begin
                pub_q   <= pm_r_q;
                sum_q   <= sum_q + (pm_r_q ^ mask_q) - mask_q;
                sel_q   <= SelPeer;
                state_q <= StPmBase;
              end
              SelPeer: begin
                peer_q  <= pm_r_q;
                sel_q   <= SelSec;
                state_q <= StPmBase;
              end
              default: begin
                sec_q   <= pm_r_q;
                state_q <= StPosMod;
              end
            endcase
          end else if (pm_d_q[0]) begin
            state_q <= StPmMulR;
          end else begin
            state_q <= StPmSqr;
          end
        end
        StPmMulR: begin
          if (issued_q && mod_rsp.done) begin
            issued_q <= 1'b0;
            pm_r_q   <= rem;
            state_q  <= StPmSqr;
          end
        end
        StPmSqr: begin
          if (issued_q && mod_rsp.done) begin
            issued_q <= 1'b0;
            pm_c_q   <= rem;
            pm_d_q   <= {1'b0, pm_d_q[7:1]};
            state_q  <= StPmLoop;
          end
        end
        StPosMod: begin
          if (issued_q && mod_rsp.done) begin
            issued_q <= 1'b0;
            pos_q    <= rem + PosOff;
            sum_q    <= sum_q + ((rem + PosOff) ^ sec_q ^ mask_q) - mask_q;
            idx_q    <= '0;
            state_q  <= StByte;
          end
        end
        StByte: begin
          out_valid_q <= 1'b1;
          out_idx_q   <= 5'(idx_q);
          out_eom_q   <= (idx_q == LastIdx);
          out_eor_q   <= (idx_q == LastIdx) && (second_q || session_q != 16'hFFFF);
          if (idx_q == '0) begin
            out_byte_q <= pub_q;
          end else if (idx_q == IdxW'(1)) begin
            out_byte_q <= pos_q ^ sec_q;
          end else begin
            out_byte_q <= plain_byte ^ sec_q;
            sum_q      <= sum_q + (plain_byte ^ sec_q ^ mask_q) - mask_q;
          end
          state_q <= StSend;
        end
        StSend: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (idx_q == LastIdx) begin
              session_q <= session_q + 16'd1;
              // A wrap of the session counter forces a reset-session message.
              if (!second_q && session_q == 16'hFFFF) begin
                second_q <= 1'b1;
                cmd_q    <= kcpe_pkg::ResetSessionCmd;
                state_q  <= StAMod;
              end else begin
                state_q <= StIdle;
              end
            end else begin
              idx_q   <= idx_q + IdxW'(1);
              state_q <= StByte;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      kcpe_pkg::RegPrime:   prdata = {24'd0, prime_q};
      kcpe_pkg::RegGen:     prdata = {24'd0, gen_q};
      kcpe_pkg::RegPartner: prdata = {24'd0, partner_q};
      kcpe_pkg::RegIdent:   prdata = {24'd0, ident_q};
      kcpe_pkg::RegMask:    prdata = {24'd0, mask_q};
      default:              prdata = 32'd0;
    endcase
  end

  assign pready           = 1'b1;
  assign in_ready_o       = (state_q == StIdle);
  assign out_valid_o      = out_valid_q;
  assign message_byte_o   = out_byte_q;
  assign byte_index_o     = out_idx_q;
  assign end_of_message_o = out_eom_q;
  assign end_of_run_o     = out_eor_q;

endmodule
